### hdl/vpmc_pkg.sv
// Package for the vehicle power mode controller: widths, codes, state,
// configuration and result types, and the pin-level table. No dependencies.
`default_nettype none

package vpmc_pkg;

  localparam int MODULE_BITS = 32;
  localparam int TIME_WIDTH  = 32;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 56;

  // register indexes of the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_WAKE_MIN   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SDP_TIME   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FORCE_TIME = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_PER   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SYNC_PER   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_REQ_MASK   = 3'd5;

  localparam logic [15:0] DEF_STEP_PER = 16'd50;
  localparam logic [7:0]  DEF_SYNC_PER = 8'd10;

  // voltage classes (6 and 7 are stored but count as unknown)
  localparam logic [2:0] VC_UNKNOWN  = 3'd0;
  localparam logic [2:0] VC_SHUT_LOW = 3'd1;
  localparam logic [2:0] VC_WAKE_OK  = 3'd3;
  localparam logic [2:0] VC_WORK_OK  = 3'd4;
  localparam logic [2:0] VC_OVER     = 3'd5;

  typedef enum logic [1:0] {
    CMD_STEP  = 2'd0,
    CMD_FORCE = 2'd1,
    CMD_VOLT  = 2'd2,
    CMD_READY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_SLEEP  = 2'd0,
    MODE_WAKEUP = 2'd1,
    MODE_WORK   = 2'd2,
    MODE_SDPREP = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    RS_INIT       = 4'd0,
    RS_KL30_LOST  = 4'd1,
    RS_KL15_ON    = 4'd2,
    RS_KL15_OFF   = 4'd3,
    RS_UNDER      = 4'd4,
    RS_OVER       = 4'd5,
    RS_WAKE_VALID = 4'd6,
    RS_WORK_VALID = 4'd7,
    RS_READY      = 4'd8,
    RS_TIMEOUT    = 4'd9,
    RS_FORCED     = 4'd10,
    RS_INVALID    = 4'd11
  } reason_t;

  typedef enum logic [1:0] {
    SYNC_NONE     = 2'd0,
    SYNC_CHANGE   = 2'd1,
    SYNC_PERIODIC = 2'd2
  } sync_t;

  typedef struct packed {
    logic        ready_req;
    logic [31:0] unit_sel;
    logic [2:0]  voltage_class;
    logic [1:0]  target_state;
    logic        kl15_on;
    logic        batt_present;
  } item_t;

  typedef struct packed {
    logic [31:0]            wake_min;
    logic [31:0]            sdp_time;
    logic [31:0]            force_time;
    logic [15:0]            step_per;
    logic [7:0]             sync_per;
    logic [MODULE_BITS-1:0] req_mask;
  } cfg_t;

  typedef struct packed {
    mode_t                  mode;
    reason_t                reason;
    logic [2:0]             vclass;
    logic [MODULE_BITS-1:0] ready;
    logic [TIME_WIDTH-1:0]  tis;
    logic [7:0]             sync_cnt;
  } state_t;

  // packed lowest field last, so it lands in the lowest bits of tdata
  typedef struct packed {
    logic        supply_low;
    logic        supply_high;
    logic [31:0] pending_mask;
    logic        sleep_ok;
    sync_t       sync_kind;
    logic        state_changed;
    logic [4:0]  pin_levels;
    reason_t     transition_reason;
    mode_t       power_state;
  } res_t;

  function automatic logic [4:0] pin_table(mode_t m);
    logic [4:0] p;
    unique case (m)
      MODE_WAKEUP: p = 5'h1A;
      MODE_WORK:   p = 5'h1B;
      default:     p = 5'h0C;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

### hdl/vpmc_step.sv
// Next-state and result logic for one item of the power mode controller.
// Purely combinational; uses vpmc_pkg.
`default_nettype none

module vpmc_step (
  input  vpmc_pkg::cmd_t   cmd,
  input  vpmc_pkg::item_t  item,
  input  vpmc_pkg::state_t cur,
  input  vpmc_pkg::cfg_t   cfg,
  output vpmc_pkg::state_t nxt,
  output vpmc_pkg::res_t   res
);

  localparam int TW = vpmc_pkg::TIME_WIDTH;

  logic [15:0]    per;
  logic [7:0]     sp;
  logic [TW:0]    t_sum;
  logic [TW-1:0]  t_sat;
  logic [31:0]    t32;
  logic           want;
  vpmc_pkg::mode_t   tgt;
  vpmc_pkg::reason_t rsn;
  logic           changed;
  logic           wake_ok;
  logic           covered;
  logic [7:0]     cnt_inc;
  logic [vpmc_pkg::MODULE_BITS-1:0] mmask;

  always_comb begin
    per     = (cfg.step_per == '0) ? vpmc_pkg::DEF_STEP_PER : cfg.step_per;
    sp      = (cfg.sync_per == '0) ? vpmc_pkg::DEF_SYNC_PER : cfg.sync_per;
    t_sum   = {1'b0, cur.tis} + (TW+1)'(per);
    t_sat   = t_sum[TW] ? {TW{1'b1}} : t_sum[TW-1:0];
    t32     = 32'(t_sat);
    wake_ok = (cur.vclass == vpmc_pkg::VC_WAKE_OK) || (cur.vclass == vpmc_pkg::VC_WORK_OK);
    covered = (cur.ready & cfg.req_mask) == cfg.req_mask;
    mmask   = item.unit_sel[vpmc_pkg::MODULE_BITS-1:0];

    // transition request for this item
    want = 1'b0;
    tgt  = cur.mode;
    rsn  = cur.reason;
    unique case (cmd)
      vpmc_pkg::CMD_STEP: begin
        want = 1'b1;
        if (!item.batt_present) begin
          tgt = vpmc_pkg::MODE_SDPREP; rsn = vpmc_pkg::RS_KL30_LOST;
        end else if (cur.vclass == vpmc_pkg::VC_SHUT_LOW) begin
          tgt = vpmc_pkg::MODE_SDPREP; rsn = vpmc_pkg::RS_UNDER;
        end else if (cur.vclass == vpmc_pkg::VC_OVER) begin
          tgt = vpmc_pkg::MODE_SDPREP; rsn = vpmc_pkg::RS_OVER;
        end else begin
          want = 1'b0;
          unique case (cur.mode)
            vpmc_pkg::MODE_SLEEP: begin
              if (item.kl15_on && wake_ok) begin
                want = 1'b1; tgt = vpmc_pkg::MODE_WAKEUP; rsn = vpmc_pkg::RS_KL15_ON;
              end
            end
            vpmc_pkg::MODE_WAKEUP: begin
              if (!item.kl15_on) begin
                want = 1'b1; tgt = vpmc_pkg::MODE_SDPREP; rsn = vpmc_pkg::RS_KL15_OFF;
              end else if (t32 >= cfg.wake_min && cur.vclass == vpmc_pkg::VC_WORK_OK) begin
                want = 1'b1; tgt = vpmc_pkg::MODE_WORK; rsn = vpmc_pkg::RS_WORK_VALID;
              end
            end
            vpmc_pkg::MODE_WORK: begin
              if (!item.kl15_on) begin
                want = 1'b1; tgt = vpmc_pkg::MODE_SDPREP; rsn = vpmc_pkg::RS_KL15_OFF;
              end else if (!wake_ok) begin
                want = 1'b1; tgt = vpmc_pkg::MODE_SDPREP; rsn = vpmc_pkg::RS_UNDER;
              end
            end
            vpmc_pkg::MODE_SDPREP: begin
              if (item.kl15_on && wake_ok) begin
                want = 1'b1; tgt = vpmc_pkg::MODE_WAKEUP; rsn = vpmc_pkg::RS_WAKE_VALID;
              end else if (t32 >= cfg.sdp_time && covered) begin
                want = 1'b1; tgt = vpmc_pkg::MODE_SLEEP; rsn = vpmc_pkg::RS_READY;
              end else if (t32 >= cfg.force_time) begin
                want = 1'b1; tgt = vpmc_pkg::MODE_SLEEP; rsn = vpmc_pkg::RS_TIMEOUT;
              end
            end
            default: want = 1'b0;
          endcase
        end
      end
      vpmc_pkg::CMD_FORCE: begin
        want = 1'b1;
        tgt  = vpmc_pkg::mode_t'(item.target_state);
        rsn  = vpmc_pkg::RS_FORCED;
      end
      default: want = 1'b0;
    endcase
    changed = want && (tgt != cur.mode);

    nxt = cur;
    unique case (cmd)
      vpmc_pkg::CMD_STEP:  nxt.tis = t_sat;
      vpmc_pkg::CMD_VOLT:  nxt.vclass = item.voltage_class;
      vpmc_pkg::CMD_READY: nxt.ready = item.ready_req ? (cur.ready | mmask)
                                                      : (cur.ready & ~mmask);
      default: nxt.tis = cur.tis;
    endcase
    if (changed) begin
      nxt.mode     = tgt;
      nxt.reason   = rsn;
      nxt.tis      = '0;
      nxt.sync_cnt = '0;
      if (tgt == vpmc_pkg::MODE_SDPREP) nxt.ready = '0;
    end

    res.sync_kind = changed ? vpmc_pkg::SYNC_CHANGE : vpmc_pkg::SYNC_NONE;
    cnt_inc = nxt.sync_cnt + 8'd1;
    if (cmd == vpmc_pkg::CMD_STEP) begin
      if (cnt_inc >= sp) begin
        nxt.sync_cnt = '0;
        if (!changed) res.sync_kind = vpmc_pkg::SYNC_PERIODIC;
      end else begin
        nxt.sync_cnt = cnt_inc;
      end
    end

    res.power_state       = nxt.mode;
    res.transition_reason = nxt.reason;
    res.pin_levels        = vpmc_pkg::pin_table(nxt.mode);
    res.state_changed     = changed;
    res.sleep_ok          = (nxt.ready & cfg.req_mask) == cfg.req_mask;
    res.pending_mask      = 32'(cfg.req_mask & ~nxt.ready);
    res.supply_high       = nxt.vclass == vpmc_pkg::VC_OVER;
    res.supply_low        = nxt.vclass == vpmc_pkg::VC_SHUT_LOW;
  end

endmodule

`default_nettype wire

### hdl/vehicle_power_mode_controller_top.sv
// Top level of the vehicle power mode controller: configuration registers,
// mode state, output register with skid stage. Uses vpmc_pkg and vpmc_step.
//
// Usage:
//   Input beats (in_*) carry one item each: in_tuser is the command (step,
//   force, voltage class update, ready-bit update), in_tdata the fields.
//   Every accepted beat produces exactly one result beat on out_*.
//   Configuration is written through cfg_wdata, one register per cycle; the user
//   must write only while no item is in flight (the block does not enforce it).
// Result path and throughput:
//   The mode rules act on the state registers, which are updated in the same
//   cycle the beat is accepted; the result is registered in the output register
//   or the skid stage. One beat per clock is sustained while out_tready is high.
// Stalls:
//   An output register plus a one-entry skid stage decouple the sides: a new
//   beat is taken while a result waits; in_tready drops only once both hold
//   results.
// Reset (rst_n low, synchronous):
//   mode sleep, reason init, voltage unknown, ready bits, time and sync count
//   cleared, configuration back to its defaults, no result pending.
`default_nettype none

module vehicle_power_mode_controller_top (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // batt_present, kl15_on, target_state[1:0], voltage_class[2:0],
  // unit_sel[31:0], ready_req
  input  wire  [vpmc_pkg::IN_DATA_W-1:0]   in_tdata,
  // command[1:0]
  input  wire  [vpmc_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // power_state[1:0], transition_reason[3:0], pin_levels[4:0], state_changed,
  // sync_kind[1:0], sleep_ok, pending_mask[31:0], supply_high,
  // supply_low, zero fill
  output logic [vpmc_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  wire                              cfg_we,
  input  wire  [vpmc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire  [vpmc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int RES_W = $bits(vpmc_pkg::res_t);

  vpmc_pkg::cfg_t   cfg_r, cfg_nxt;
  vpmc_pkg::state_t st_r, st_nxt, st_step;
  vpmc_pkg::res_t   res_step;
  vpmc_pkg::res_t   out_r, out_nxt, skid_r, skid_nxt;
  logic             out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic             acc, take;

  assign in_tready  = !skid_valid_r;
  assign acc        = in_tvalid && in_tready;
  assign take       = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(vpmc_pkg::OUT_DATA_W - RES_W)'(0), out_r};

  vpmc_step u_step (
    .cmd  (vpmc_pkg::cmd_t'(in_tuser)),
    .item (vpmc_pkg::item_t'(in_tdata)),
    .cur  (st_r),
    .cfg  (cfg_r),
    .nxt  (st_step),
    .res  (res_step)
  );

  // configuration decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        vpmc_pkg::REG_WAKE_MIN:   cfg_nxt.wake_min   = cfg_wdata;
        vpmc_pkg::REG_SDP_TIME:   cfg_nxt.sdp_time   = cfg_wdata;
        vpmc_pkg::REG_FORCE_TIME: cfg_nxt.force_time = cfg_wdata;
        vpmc_pkg::REG_STEP_PER:   cfg_nxt.step_per   = cfg_wdata[15:0];
        vpmc_pkg::REG_SYNC_PER:   cfg_nxt.sync_per   = cfg_wdata[7:0];
        vpmc_pkg::REG_REQ_MASK:
          cfg_nxt.req_mask = cfg_wdata[vpmc_pkg::MODULE_BITS-1:0];
        default: cfg_nxt = cfg_r;  // unmapped index, write ignored
      endcase
    end
  end

  // state advances only on an accepted beat
  assign st_nxt = acc ? st_step : st_r;

  // output register and skid stage
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (take) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (acc) begin
      if (!out_valid_r || take) begin
        out_nxt       = res_step;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res_step;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wake_min   <= 32'd500;
      cfg_r.sdp_time   <= 32'd2000;
      cfg_r.force_time <= 32'd10000;
      cfg_r.step_per   <= vpmc_pkg::DEF_STEP_PER;
      cfg_r.sync_per   <= vpmc_pkg::DEF_SYNC_PER;
      cfg_r.req_mask   <= '0;
      st_r.mode        <= vpmc_pkg::MODE_SLEEP;
      st_r.reason      <= vpmc_pkg::RS_INIT;
      st_r.vclass      <= vpmc_pkg::VC_UNKNOWN;
      st_r.ready       <= '0;
      st_r.tis         <= '0;
      st_r.sync_cnt    <= '0;
      out_valid_r      <= 1'b0;
      skid_valid_r     <= 1'b0;
    end else begin
      cfg_r        <= cfg_nxt;
      st_r         <= st_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

### hdl/vpmc_checker.sv
// Port-level checks for the power mode controller, bound to the top level.
// Depends on vpmc_pkg and vehicle_power_mode_controller_top.
`default_nettype none

module vpmc_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [vpmc_pkg::OUT_DATA_W-1:0]   out_tdata
);

  // a result shows the pin levels of the mode it reports
  a_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      (out_tdata[10:6] == vpmc_pkg::pin_table(vpmc_pkg::mode_t'(out_tdata[1:0]))))
    else $error("pin levels do not match mode");

  // a transition always comes with a change sync
  a_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[11]) |-> (out_tdata[13:12] == vpmc_pkg::SYNC_CHANGE))
    else $error("state change without change sync");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[14] == (out_tdata[46:15] == 32'd0)))
    else $error("sleep_ok disagrees with pending mask");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind vehicle_power_mode_controller_top vpmc_checker u_vpmc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
